@@ src/mi3_pkg.sv @@
// Shared constants for the 3x3 matrix inverse and determinant unit.
package mi3_pkg;

	localparam int ELEM_WIDTH_DEF = 16;
	localparam int OUT_WIDTH_DEF  = 32;
	localparam int FRAC_IN        = 12;
	localparam int FRAC_OUT       = 16;
	localparam int FRAC_SUM       = FRAC_IN + FRAC_OUT + 1;
	localparam int NUM_ELEM       = 9;

endpackage

@@ src/mi3_div_lane.sv @@
// Pipelined restoring divider lane, one quotient bit per stage, with overflow detect.
module mi3_div_lane #(
	parameter int NW = 33,
	parameter int DW = 50,
	parameter int K  = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          in_neg,
	output logic          out_valid,
	output logic [K-1:0]  quo,
	output logic          out_neg,
	output logic          out_sat
);
	import mi3_pkg::*;

	localparam int NXW  = NW + FRAC_SUM + K;
	localparam int RW   = DW + 1;
	localparam int CMPW = NXW + DW;

	logic [NXW-1:0] nx;
	logic           sat_c;

	logic [DW-1:0]  rem_s [0:K];
	logic [K-1:0]   low_s [0:K];
	logic [K-1:0]   quo_s [0:K];
	logic [DW-1:0]  den_s [0:K];
	logic           neg_s [0:K];
	logic           sat_s [0:K];
	logic           vld_s [0:K];

	always_comb begin
		nx    = NXW'(num) << FRAC_SUM;
		sat_c = (CMPW'(nx) >= (CMPW'(den) << K));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DW'(nx >> K);
		low_s[0] <= nx[K-1:0];
		quo_s[0] <= '0;
		den_s[0] <= den;
		neg_s[0] <= in_neg;
		sat_s[0] <= sat_c;
	end

	for (genvar s = 1; s <= K; s++) begin : g_step
		logic [RW-1:0] rs;
		logic          ge;

		always_comb begin
			rs = {rem_s[s-1], low_s[s-1][K-1]};
			ge = (rs >= {1'b0, den_s[s-1]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= vld_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[s] <= ge ? DW'(rs - {1'b0, den_s[s-1]}) : rs[DW-1:0];
			low_s[s] <= low_s[s-1] << 1;
			quo_s[s] <= {quo_s[s-1][K-2:0], ge};
			den_s[s] <= den_s[s-1];
			neg_s[s] <= neg_s[s-1];
			sat_s[s] <= sat_s[s-1];
		end
	end

	assign out_valid = vld_s[K];
	assign quo       = quo_s[K];
	assign out_neg   = neg_s[K];
	assign out_sat   = sat_s[K];

endmodule

@@ src/matrix3_inverse_determinant_unit.sv @@
// Top level of the 3x3 matrix inverse and determinant unit.
// A request passes through stages s1 to s6, the divider lanes and the output register before done.
// One request is accepted every cycle; busy is always low and results cannot be stalled.
// The divider runs one quotient bit per stage across nine parallel lanes.
// Reset clears all stage valid bits; data registers are not reset.
module matrix3_inverse_determinant_unit #(
	parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
	parameter int OUT_WIDTH  = mi3_pkg::OUT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [ELEM_WIDTH-1:0] a11,
	input  logic signed [ELEM_WIDTH-1:0] a12,
	input  logic signed [ELEM_WIDTH-1:0] a13,
	input  logic signed [ELEM_WIDTH-1:0] a21,
	input  logic signed [ELEM_WIDTH-1:0] a22,
	input  logic signed [ELEM_WIDTH-1:0] a23,
	input  logic signed [ELEM_WIDTH-1:0] a31,
	input  logic signed [ELEM_WIDTH-1:0] a32,
	input  logic signed [ELEM_WIDTH-1:0] a33,
	output logic                        done,
	output logic signed [OUT_WIDTH-1:0] b11,
	output logic signed [OUT_WIDTH-1:0] b12,
	output logic signed [OUT_WIDTH-1:0] b13,
	output logic signed [OUT_WIDTH-1:0] b21,
	output logic signed [OUT_WIDTH-1:0] b22,
	output logic signed [OUT_WIDTH-1:0] b23,
	output logic signed [OUT_WIDTH-1:0] b31,
	output logic signed [OUT_WIDTH-1:0] b32,
	output logic signed [OUT_WIDTH-1:0] b33,
	output logic signed [3*ELEM_WIDTH+1:0] determinant,
	output logic                        singular,
	output logic                        saturated
);
	import mi3_pkg::*;

	localparam int E   = ELEM_WIDTH;
	localparam int PW  = 2 * E;
	localparam int CW  = 2 * E + 1;
	localparam int DPW = E + CW;
	localparam int DW  = 3 * E + 2;
	localparam int K   = OUT_WIDTH + 1;
	localparam int SHW = E + FRAC_OUT - FRAC_IN;
	localparam int MW  = (K > SHW) ? K : SHW;

	logic signed [E-1:0]   m_in [0:NUM_ELEM-1];

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [E-1:0]   m_s1 [0:NUM_ELEM-1];
	logic signed [E-1:0]   m_s2 [0:NUM_ELEM-1];
	logic signed [E-1:0]   m_s3 [0:NUM_ELEM-1];
	logic signed [E-1:0]   m_s4 [0:NUM_ELEM-1];
	logic signed [E-1:0]   m_s5 [0:NUM_ELEM-1];
	logic signed [E-1:0]   m_s6 [0:NUM_ELEM-1];
	logic signed [PW-1:0]  pa_s2 [0:NUM_ELEM-1];
	logic signed [PW-1:0]  pb_s2 [0:NUM_ELEM-1];
	logic signed [CW-1:0]  cof_s3 [0:NUM_ELEM-1];
	logic signed [CW-1:0]  cof_s4 [0:NUM_ELEM-1];
	logic signed [CW-1:0]  cof_s5 [0:NUM_ELEM-1];
	logic signed [DPW-1:0] dp_s4 [0:2];
	logic signed [DW-1:0]  det_s5;
	logic signed [DW-1:0]  det_s6;
	logic [DW-1:0]         dmag_s6;
	logic                  sing_s6;
	logic [CW-1:0]         nmag_s6 [0:NUM_ELEM-1];
	logic                  neg_s6 [0:NUM_ELEM-1];

	logic signed [DW-1:0]  det_d [0:K];
	logic                  sing_d [0:K];
	logic signed [E-1:0]   m_d [0:K][0:NUM_ELEM-1];

	logic                  lane_vld [0:NUM_ELEM-1];
	logic [K-1:0]          lane_quo [0:NUM_ELEM-1];
	logic                  lane_neg [0:NUM_ELEM-1];
	logic                  lane_sat [0:NUM_ELEM-1];

	logic [OUT_WIDTH-1:0]  bval [0:NUM_ELEM-1];
	logic                  bclip [0:NUM_ELEM-1];
	logic [NUM_ELEM-1:0]   clip_vec;

	logic                  vld_so;
	logic signed [OUT_WIDTH-1:0] b_so [0:NUM_ELEM-1];
	logic signed [DW-1:0]  det_so;
	logic                  sing_so;
	logic                  sat_so;

	assign busy = 1'b0;

	assign m_in[0] = a11;
	assign m_in[1] = a12;
	assign m_in[2] = a13;
	assign m_in[3] = a21;
	assign m_in[4] = a22;
	assign m_in[5] = a23;
	assign m_in[6] = a31;
	assign m_in[7] = a32;
	assign m_in[8] = a33;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_so <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_so <= lane_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		m_s1   <= m_in;
		m_s2   <= m_s1;
		m_s3   <= m_s2;
		m_s4   <= m_s3;
		m_s5   <= m_s4;
		m_s6   <= m_s5;
		cof_s4 <= cof_s3;
		cof_s5 <= cof_s4;
		det_s5 <= DW'(dp_s4[0]) + DW'(dp_s4[1]) + DW'(dp_s4[2]);
		det_s6 <= det_s5;
		dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
		sing_s6 <= (det_s5 == '0);
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			localparam int I1 = (i + 1) % 3;
			localparam int I2 = (i + 2) % 3;
			localparam int J1 = (j + 1) % 3;
			localparam int J2 = (j + 2) % 3;
			localparam int IX = 3 * i + j;

			always_ff @(posedge clk) begin
				pa_s2[IX]  <= PW'(m_s1[3*I1+J1] * m_s1[3*I2+J2]);
				pb_s2[IX]  <= PW'(m_s1[3*I1+J2] * m_s1[3*I2+J1]);
				cof_s3[IX] <= CW'(pa_s2[IX]) - CW'(pb_s2[IX]);
				nmag_s6[IX] <= cof_s5[IX][CW-1] ? CW'(-cof_s5[IX]) : CW'(cof_s5[IX]);
				neg_s6[IX]  <= cof_s5[IX][CW-1] ^ det_s5[DW-1];
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_detp
		always_ff @(posedge clk) begin
			dp_s4[j] <= DPW'(m_s3[j]) * DPW'(cof_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		det_d[0]  <= det_s6;
		sing_d[0] <= sing_s6;
		m_d[0]    <= m_s6;
	end

	for (genvar s = 1; s <= K; s++) begin : g_side
		always_ff @(posedge clk) begin
			det_d[s]  <= det_d[s-1];
			sing_d[s] <= sing_d[s-1];
			m_d[s]    <= m_d[s-1];
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lrow
		for (genvar j = 0; j < 3; j++) begin : g_lcol
			localparam int IX = 3 * i + j;
			localparam int CX = 3 * j + i;

			logic [MW-1:0] mag;
			logic          ng;
			logic          ovf;
			logic [MW-1:0] lim;
			logic [K:0]    qr;
			logic          ve;

			mi3_div_lane #(
				.NW(CW),
				.DW(DW),
				.K (K)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (vld_s6),
				.num      (nmag_s6[CX]),
				.den      (dmag_s6),
				.in_neg   (neg_s6[CX]),
				.out_valid(lane_vld[IX]),
				.quo      (lane_quo[IX]),
				.out_neg  (lane_neg[IX]),
				.out_sat  (lane_sat[IX])
			);

			always_comb begin
				lim = MW'(1) << (OUT_WIDTH - 1);
				qr  = ({1'b0, lane_quo[IX]} + (K+1)'(1)) >> 1;
				ve  = m_d[K][IX][E-1];
				if (sing_d[K]) begin
					ng  = ve;
					mag = MW'(ve ? SHW'(-m_d[K][IX]) : SHW'(m_d[K][IX]))
						<< (FRAC_OUT - FRAC_IN);
					ovf = 1'b0;
				end else begin
					ng  = lane_neg[IX];
					mag = MW'(qr);
					ovf = lane_sat[IX];
				end
				if (ng) begin
					bclip[IX] = ovf || (mag > lim);
					bval[IX]  = bclip[IX] ? OUT_WIDTH'(-lim) : OUT_WIDTH'(-mag);
				end else begin
					bclip[IX] = ovf || (mag > lim - MW'(1));
					bval[IX]  = bclip[IX] ? OUT_WIDTH'(lim - MW'(1)) : OUT_WIDTH'(mag);
				end
				clip_vec[IX] = bclip[IX];
			end

			always_ff @(posedge clk) begin
				b_so[IX] <= bval[IX];
			end
		end
	end

	always_ff @(posedge clk) begin
		det_so  <= det_d[K];
		sing_so <= sing_d[K];
		sat_so  <= |clip_vec;
	end

	assign done        = vld_so;
	assign b11         = b_so[0];
	assign b12         = b_so[1];
	assign b13         = b_so[2];
	assign b21         = b_so[3];
	assign b22         = b_so[4];
	assign b23         = b_so[5];
	assign b31         = b_so[6];
	assign b32         = b_so[7];
	assign b33         = b_so[8];
	assign determinant = det_so;
	assign singular    = sing_so;
	assign saturated   = sat_so;

endmodule
